@@ sv/srde_pkg.sv @@
// ---------------------------------------------------------------------------
// srde_pkg
// Shared constants and codes for the signed radix digit emitter.
// ---------------------------------------------------------------------------
package srde_pkg;

    // Width of one alphabet symbol and of one emitted character.
    localparam int unsigned SYM_W = 8;

    // Default sizes handed to the top level.
    localparam int unsigned MAX_SYMBOLS_DEF  = 256;
    localparam int unsigned NUMBER_WIDTH_DEF = 32;

    // Sign characters, which are never allowed in an alphabet.
    localparam logic [SYM_W-1:0] SIGN_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SIGN_PLUS  = 8'h2B;

    // Action codes carried in the input tuser.
    typedef enum logic {
        ACT_LOAD    = 1'b0,
        ACT_CONVERT = 1'b1
    } t_action;

endpackage

@@ sv/signed_radix_digit_emitter_core.sv @@
// ---------------------------------------------------------------------------
// signed_radix_digit_emitter_core
// Writes a signed integer as characters of an alphabet that is loaded one
// symbol at a time; the number of symbols loaded is the base.
// ---------------------------------------------------------------------------
//
//  Channel  | Direction | tdata (lowest bit up)        | Side bits
//  ---------+-----------+------------------------------+---------------------
//  s_axis   | in        | symbol[7:0], number, zeros   | tuser = action
//  m_axis   | out       | character[7:0]               | tlast = last
//
// A convert transaction with an invalid alphabet gives no output. A valid
// convert starts the shared compare-and-subtract divider (one quotient bit
// per cycle, up to NUMBER_WIDTH digits), then emits an optional minus sign
// and each digit character with an alphabet read followed by output; the
// output stalls while m_axis_tready is held low. The input is not ready
// until the last character of a conversion is taken. Reset is synchronous
// and active low.
// ---------------------------------------------------------------------------
module signed_radix_digit_emitter_core #(
    parameter int unsigned MAX_SYMBOLS  = srde_pkg::MAX_SYMBOLS_DEF,
    parameter int unsigned NUMBER_WIDTH = srde_pkg::NUMBER_WIDTH_DEF,
    localparam int unsigned IN_DATA_W   =
        ((NUMBER_WIDTH + srde_pkg::SYM_W + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input stream.
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata fields, lowest bit up: symbol (8), number (NUMBER_WIDTH), zero fill.
    input  logic [IN_DATA_W-1:0]        s_axis_tdata,
    // tuser fields: action (1).
    input  logic                        s_axis_tuser,
    // Output stream.
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // tdata fields, lowest bit up: character (8).
    output logic [srde_pkg::SYM_W-1:0]  m_axis_tdata,
    output logic                        m_axis_tlast
);
    import srde_pkg::*;

    localparam int unsigned W   = NUMBER_WIDTH;
    // Bits of an alphabet address, which is also the width of one digit.
    localparam int unsigned AW  = $clog2(MAX_SYMBOLS);
    // Bits of the symbol count, which must hold MAX_SYMBOLS itself.
    localparam int unsigned CW  = $clog2(MAX_SYMBOLS + 1);
    // Bits of the digit count (0..W) and of a digit stack index.
    localparam int unsigned NW  = $clog2(W + 1);
    localparam int unsigned SIW = $clog2(W);
    // Bits of the divider's bit counter.
    localparam int unsigned BW  = $clog2(W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_FETCH,
        ST_SEND
    } t_state;

    t_state            r_state;

    // Alphabet bookkeeping.
    logic [CW-1:0]     r_count;
    logic              r_bad;
    logic [255:0]      r_seen;
    logic [SYM_W-1:0]  r_alpha [MAX_SYMBOLS];
    logic [SYM_W-1:0]  r_mem_q;

    // Divider and digit stack.
    logic [CW-1:0]     r_base;
    logic              r_neg;
    logic [W-1:0]      r_mag;
    logic [AW-1:0]     r_rem;
    logic [BW-1:0]     r_bit;
    logic [NW-1:0]     r_digits;
    logic [AW-1:0]     r_stack [W];

    // Input fields.
    logic [SYM_W-1:0]  w_sym;
    logic [W-1:0]      w_num;
    logic              w_accept;
    logic              w_load_ok;

    // Shared compare-and-subtract step.
    logic [AW:0]       w_shift;
    logic [AW:0]       w_base_x;
    logic [AW:0]       w_diff;
    logic              w_ge;
    logic [AW-1:0]     n_rem;
    logic [W-1:0]      n_mag;
    logic              w_digit_done;
    logic [NW-1:0]     w_top_full;
    logic [SIW-1:0]    w_top;

    assign w_sym    = s_axis_tdata[SYM_W-1:0];
    assign w_num    = s_axis_tdata[SYM_W +: W];
    assign w_accept = s_axis_tvalid && s_axis_tready;

    // A nonzero symbol is stored only while the store still has room.
    assign w_load_ok = w_accept && (t_action'(s_axis_tuser) == ACT_LOAD)
                       && (w_sym != '0) && (r_count < CW'(MAX_SYMBOLS));

    // One restoring division step: bring down the next dividend bit and
    // subtract the base when it fits. After W steps r_mag holds the quotient,
    // and the remainder of the last step, n_rem, is the next digit.
    always_comb begin
        w_shift  = {r_rem, r_mag[W-1]};
        w_base_x = (AW+1)'(r_base);
        w_ge     = (w_shift >= w_base_x);
        w_diff   = w_shift - w_base_x;
        n_rem    = w_ge ? w_diff[AW-1:0] : w_shift[AW-1:0];
        n_mag    = {r_mag[W-2:0], w_ge};
    end

    assign w_digit_done = (r_state == ST_DIV) && (r_bit == BW'(W - 1));
    assign w_top_full   = r_digits - NW'(1);
    assign w_top        = w_top_full[SIW-1:0];

    // Handshake and output decode.
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_SIGN) || (r_state == ST_SEND);
    assign m_axis_tdata  = (r_state == ST_SIGN) ? SIGN_MINUS : r_mem_q;
    assign m_axis_tlast  = (r_state == ST_SEND) && (r_digits == NW'(1));

    // Alphabet store: written by load transactions, read once per character.
    always_ff @(posedge i_clk) begin
        if (w_load_ok) begin
            r_alpha[r_count[AW-1:0]] <= w_sym;
        end
        if (r_state == ST_FETCH) begin
            r_mem_q <= r_alpha[r_stack[w_top]];
        end
    end

    // Digit stack: digits arrive least significant first and leave from the top.
    always_ff @(posedge i_clk) begin
        if (w_digit_done) begin
            r_stack[r_digits[SIW-1:0]] <= n_rem;
        end
    end

    // Sequencer and alphabet state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_bad    <= 1'b0;
            r_seen   <= '0;
            r_digits <= '0;
            r_bit    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (t_action'(s_axis_tuser) == ACT_LOAD) begin
                            // A zero byte is ignored. A repeat, a sign or an
                            // overflowing load spoils the alphabet.
                            if (w_sym != '0) begin
                                if (r_seen[w_sym] || (w_sym == SIGN_MINUS) ||
                                    (w_sym == SIGN_PLUS) ||
                                    (r_count == CW'(MAX_SYMBOLS))) begin
                                    r_bad <= 1'b1;
                                end
                                r_seen[w_sym] <= 1'b1;
                                if (r_count < CW'(MAX_SYMBOLS)) begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                        end else begin
                            // Every convert clears the alphabet; the base
                            // is kept in r_base for this conversion.
                            r_count <= '0;
                            r_bad   <= 1'b0;
                            r_seen  <= '0;
                            if (!r_bad && (r_count >= CW'(2))) begin
                                r_base   <= r_count;
                                r_neg    <= w_num[W-1];
                                r_mag    <= w_num[W-1] ? (~w_num + W'(1)) : w_num;
                                r_rem    <= '0;
                                r_bit    <= '0;
                                r_digits <= '0;
                                r_state  <= ST_DIV;
                            end
                        end
                    end
                end
                ST_DIV: begin
                    r_mag <= n_mag;
                    if (w_digit_done) begin
                        r_rem    <= '0;
                        r_bit    <= '0;
                        r_digits <= r_digits + NW'(1);
                        if ((n_mag == '0) || (r_digits == NW'(W - 1))) begin
                            r_state <= r_neg ? ST_SIGN : ST_FETCH;
                        end
                    end else begin
                        r_rem <= n_rem;
                        r_bit <= r_bit + BW'(1);
                    end
                end
                ST_SIGN: begin
                    if (m_axis_tready) begin
                        r_state <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    r_state <= ST_SEND;
                end
                ST_SEND: begin
                    if (m_axis_tready) begin
                        r_digits <= w_top_full;
                        r_state  <= (r_digits == NW'(1)) ? ST_IDLE : ST_FETCH;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/srde_checker.sv @@
// ---------------------------------------------------------------------------
// srde_checker
// Port-level checks for the signed radix digit emitter, bound to its top.
// ---------------------------------------------------------------------------
module srde_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        s_axis_tuser,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [srde_pkg::SYM_W-1:0]  m_axis_tdata,
    input logic                        m_axis_tlast
);
    import srde_pkg::*;

    // A character offered but not taken stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    // No new input is taken while a conversion is still being emitted.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while output pending");

    // Reset leaves no output pending.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A load transaction produces no character.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (t_action'(s_axis_tuser) == ACT_LOAD)
            |=> !m_axis_tvalid)
        else $error("character after load transaction");

    // The final character of a conversion returns the block to ready.
    a_last_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("not ready after final character");

endmodule

bind signed_radix_digit_emitter_core srde_checker u_srde_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ test/srde_char_checker.sv @@
// ---------------------------------------------------------------------------
// srde_char_checker
// Watches both streams of the digit emitter, predicts the characters of each
// convert transaction and compares every output transaction in order.
// ---------------------------------------------------------------------------
module srde_char_checker #(
    parameter int unsigned MAX_SYMBOLS  = srde_pkg::MAX_SYMBOLS_DEF,
    parameter int unsigned NUMBER_WIDTH = srde_pkg::NUMBER_WIDTH_DEF,
    localparam int unsigned IN_W = ((NUMBER_WIDTH + srde_pkg::SYM_W + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_tvalid,
    input  logic                        i_in_tready,
    // tdata fields, lowest bit up: symbol (8), number (NUMBER_WIDTH), zero fill.
    input  logic [IN_W-1:0]             i_in_tdata,
    // tuser fields: action (1).
    input  logic                        i_in_tuser,
    input  logic                        i_out_tvalid,
    input  logic                        i_out_tready,
    // tdata fields, lowest bit up: character (8).
    input  logic [srde_pkg::SYM_W-1:0]  i_out_tdata,
    input  logic                        i_out_tlast,
    output int                          o_fail_count,
    output int                          o_pending
);
    import srde_pkg::*;

    typedef struct packed {
        logic [SYM_W-1:0] chr;
        logic             is_last;
    } t_char_beat;

    t_char_beat       expected_chars [$];
    t_char_beat       want;
    logic [SYM_W-1:0] alphabet [MAX_SYMBOLS];
    bit               symbol_used [256];
    int unsigned      symbol_total = 0;
    bit               alphabet_broken = 1'b0;
    int               fail_total = 0;

    function automatic void forget_alphabet();
        foreach (symbol_used[i]) symbol_used[i] = 1'b0;
        symbol_total    = 0;
        alphabet_broken = 1'b0;
    endfunction

    function automatic void take_symbol(logic [SYM_W-1:0] sym);
        if (sym == '0) return;
        if (symbol_used[sym] || sym == SIGN_MINUS || sym == SIGN_PLUS) alphabet_broken = 1'b1;
        symbol_used[sym] = 1'b1;
        if (symbol_total < MAX_SYMBOLS) begin
            alphabet[symbol_total] = sym;
            symbol_total++;
        end else begin
            alphabet_broken = 1'b1;
        end
    endfunction

    // Queues the characters of one convert transaction, then drops the alphabet.
    function automatic void predict_characters(logic [NUMBER_WIDTH-1:0] value);
        logic [NUMBER_WIDTH-1:0] magnitude;
        int unsigned             digit_idx [$];
        int unsigned             radix;
        t_char_beat              beat;
        if (!alphabet_broken && symbol_total >= 2) begin
            radix     = symbol_total;
            magnitude = value[NUMBER_WIDTH-1] ? (~value + 1'b1) : value;
            do begin
                digit_idx.push_back(magnitude % radix);
                magnitude = magnitude / radix;
            end while (magnitude != 0 && digit_idx.size() < NUMBER_WIDTH);
            if (value[NUMBER_WIDTH-1]) begin
                beat.chr     = SIGN_MINUS;
                beat.is_last = 1'b0;
                expected_chars.push_back(beat);
            end
            for (int i = digit_idx.size() - 1; i >= 0; i--) begin
                beat.chr     = alphabet[digit_idx[i]];
                beat.is_last = (i == 0);
                expected_chars.push_back(beat);
            end
        end
        forget_alphabet();
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            forget_alphabet();
            expected_chars.delete();
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                if (expected_chars.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected character, expected none, got %h last %b",
                             $time, i_out_tdata, i_out_tlast);
                end else begin
                    want = expected_chars.pop_front();
                    if (i_out_tdata !== want.chr || i_out_tlast !== want.is_last) begin
                        fail_total++;
                        $display("%0t: character expected %h got %h, last expected %b got %b",
                                 $time, want.chr, i_out_tdata, want.is_last, i_out_tlast);
                    end
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                if (t_action'(i_in_tuser) == ACT_LOAD) begin
                    take_symbol(i_in_tdata[SYM_W-1:0]);
                end else begin
                    predict_characters(i_in_tdata[SYM_W +: NUMBER_WIDTH]);
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_chars.size();
    end

endmodule

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Drives the signed radix digit emitter with alphabet loads and convert
// transactions and gives the verdict; the checker beside it predicts and
// compares every character.
// ---------------------------------------------------------------------------
module tb_top;
    import srde_pkg::*;

    localparam int unsigned NUMBER_W     = NUMBER_WIDTH_DEF;
    localparam int unsigned IN_W         = ((NUMBER_W + SYM_W + 7) / 8) * 8;
    // Even if every transaction were a base-2 convert, the slowest kind in the
    // divider, with the receiver stalling long on each character, the run
    // stays well below this limit.
    localparam int unsigned CYCLE_LIMIT  = 6_000_000;
    // Long enough for the slowest convert to finish after the input goes quiet.
    localparam int unsigned DRAIN_CYCLES = 1200;
    // Length of the one long receiver hold-off.
    localparam int unsigned HOLD_CYCLES  = 400;
    // Transactions in the whole run, directed part included.
    localparam int unsigned TOTAL_ITEMS  = 260;
    // Size of the large directed alphabet; above 128 so that digits use
    // their top bit.
    localparam int unsigned LARGE_BASE   = 136;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata fields, lowest bit up: symbol (8), number (32), zero fill.
    logic [IN_W-1:0]       s_axis_tdata  = '0;
    // tuser fields: action (1).
    logic                  s_axis_tuser  = ACT_LOAD;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata fields, lowest bit up: character (8).
    logic [SYM_W-1:0]      m_axis_tdata;
    logic                  m_axis_tlast;

    int                    fail_count;
    int                    pending_chars;

    // Sender bookkeeping: transactions left in the current burst, and a count
    // of accepted transactions that the block does not simply ignore.
    int                    burst_left = 0;
    int                    items_done = 0;
    // Set once the random part starts; the receiver then holds off once.
    bit                    hold_armed = 1'b0;

    signed_radix_digit_emitter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    srde_char_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .i_out_tlast  (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_chars)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Offers one transaction and returns at the edge where it is accepted.
    // Between bursts of random length the sender drops tvalid for a random
    // gap; a gap of zero keeps tvalid high so that bursts run back to back.
    task automatic send_item(input t_action act, input logic [SYM_W-1:0] sym,
                             input logic [NUMBER_W-1:0] num);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= IN_W'({num, sym});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (!(act == ACT_LOAD && sym == '0)) items_done++;
    endtask

    // The field that an action does not use still carries random bits, so
    // that the block is seen to ignore it.
    task automatic load_sym(input logic [SYM_W-1:0] sym);
        send_item(ACT_LOAD, sym, NUMBER_W'($urandom));
    endtask

    task automatic convert_num(input logic [NUMBER_W-1:0] num);
        send_item(ACT_CONVERT, SYM_W'($urandom), num);
    endtask

    // Numbers lean on the edges: zero, the most negative and most positive
    // values, minus one and small values around zero, else anything at all.
    function automatic logic [NUMBER_W-1:0] pick_number();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return {1'b1, {(NUMBER_W-1){1'b0}}};
            2: return {1'b0, {(NUMBER_W-1){1'b1}}};
            3: return '1;
            4: return NUMBER_W'($urandom_range(0, 40)) - NUMBER_W'(20);
            default: return NUMBER_W'($urandom);
        endcase
    endfunction

    // One alphabet followed by a convert. Most alphabets are clean sets of
    // distinct symbols, so that the divider and the emitter get real work;
    // the rest repeat a symbol, hold a sign, or are too short to be a base.
    // Now and then a zero symbol is slipped in, which must change nothing.
    task automatic random_sequence();
        bit               taken [256];
        logic [SYM_W-1:0] picked [$];
        int               style;
        int               length;
        int               spot;
        logic [SYM_W-1:0] sym;
        style = $urandom_range(0, 9);
        case ($urandom_range(0, 9))
            0, 1:          length = 2;
            2, 3, 4, 5, 6: length = $urandom_range(3, 12);
            7, 8:          length = $urandom_range(13, 40);
            default:       length = $urandom_range(41, 64);
        endcase
        if (style == 9) length = $urandom_range(0, 1);
        while (picked.size() < length) begin
            sym = SYM_W'($urandom_range(1, 255));
            if (!taken[sym] && sym != SIGN_MINUS && sym != SIGN_PLUS) begin
                taken[sym] = 1'b1;
                picked.push_back(sym);
            end
        end
        if (style == 7) begin
            spot = $urandom_range(0, picked.size() - 1);
            picked.insert($urandom_range(0, picked.size()), picked[spot]);
        end else if (style == 8) begin
            picked.insert($urandom_range(0, picked.size()),
                          ($urandom_range(0, 1) == 1) ? SIGN_MINUS : SIGN_PLUS);
        end
        foreach (picked[i]) begin
            if ($urandom_range(0, 15) == 0) load_sym('0);
            load_sym(picked[i]);
        end
        convert_num(pick_number());
    endtask

    // The receiver alternates between runs where it is always ready, runs
    // where it flips a coin each cycle, and runs where it is mostly stalled.
    // Once the random part is under way it holds off for a long stretch while
    // a conversion is in flight, so the block backs up and stalls its input.
    initial begin : sink_pattern
        int mode;
        int run_len;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_armed && pending_chars != 0) begin
                hold_armed = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            mode    = $urandom_range(0, 2);
            run_len = $urandom_range(4, 60);
            repeat (run_len) begin
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                    default: m_axis_tready <= ($urandom_range(0, 5) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Run limit: reaching it means the block hung or lost characters.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        logic [SYM_W-1:0] full_set [$];
        logic [SYM_W-1:0] swap;
        int               j;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part.
        // A convert with an empty alphabet, then with a single symbol: both
        // are too short to form a base and give nothing.
        convert_num(pick_number());
        load_sym("A");
        convert_num(pick_number());
        // Base two with a zero symbol in between, which is dropped. The most
        // negative number comes out as a minus sign and 32 digits.
        load_sym("x");
        load_sym('0);
        load_sym("y");
        convert_num({1'b1, {(NUMBER_W-1){1'b0}}});
        // The extreme symbol bytes as an alphabet; zero gives one character,
        // the first symbol.
        load_sym(8'hFF);
        load_sym(8'h01);
        convert_num('0);
        // A repeated symbol spoils the alphabet.
        load_sym("a");
        load_sym("b");
        load_sym("a");
        convert_num(pick_number());
        // A plus or a minus in the alphabet spoils it as well.
        load_sym("a");
        load_sym(SIGN_PLUS);
        convert_num(pick_number());
        load_sym(SIGN_MINUS);
        load_sym("b");
        convert_num(pick_number());
        // Base three on the most positive number.
        load_sym("0");
        load_sym("1");
        load_sym("2");
        convert_num({1'b0, {(NUMBER_W-1){1'b1}}});

        // A large alphabet of distinct bytes, drawn at random from every byte
        // but zero and the two signs.
        for (int v = 1; v < 256; v++) begin
            if (v != SIGN_MINUS && v != SIGN_PLUS) full_set.push_back(SYM_W'(v));
        end
        for (int i = full_set.size() - 1; i > 0; i--) begin
            j           = $urandom_range(0, i);
            swap        = full_set[i];
            full_set[i] = full_set[j];
            full_set[j] = swap;
        end
        for (int i = 0; i < LARGE_BASE; i++) load_sym(full_set[i]);
        convert_num(pick_number());

        // Random part, until the run reaches its transaction count.
        hold_armed = 1'b1;
        while (items_done < TOTAL_ITEMS) random_sequence();

        // Drain: wait for every predicted character, then a quiet stretch in
        // which any stray output transaction would still be caught.
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_chars != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
